// ===== design/fnv512_pkg.sv =====
// Shared types, constants and hash step functions for the 512-bit FNV core.
package fnv512_pkg;

	localparam int HASH_W = 512;
	localparam int WORD_W = 64;
	localparam int WORDS = HASH_W / WORD_W;
	localparam int IDX_W = $clog2(WORDS);
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [8:0] PRIME_LOW = 9'h157;
	localparam int PRIME_SHIFT = 344;

	localparam logic [HASH_W-1:0] OFFSET_BASIS = {
		64'hB86DB0B1171F4416, 64'hDCA1E50F309990AC,
		64'hAC87D059C9000000, 64'h0000000000000D21,
		64'hE948F68A34C192F6, 64'h2EA79BC942DBE7CE,
		64'h182036415F56E34B, 64'hAC982AAC4AFE9FD9
	};

	typedef enum logic [1:0] {
		OP_ABSORB        = 2'd0,
		OP_ABSORB_FINISH = 2'd1,
		OP_FINISH        = 2'd2,
		OP_NONE          = 2'd3
	} op_e;

	typedef enum logic [1:0] {
		VAR_FNV0  = 2'd0,
		VAR_FNV1  = 2'd1,
		VAR_FNV1A = 2'd2,
		VAR_ALT1A = 2'd3
	} variant_e;

	localparam logic [PADDR_W-1:0] REG_HASH_VARIANT = 3'd0;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] data_byte;
	} cmd_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] digest_word;
		logic [IDX_W-1:0]  word_index;
		logic              last_word;
	} res_item_t;

	// classified work item passed from front to back
	typedef struct packed {
		logic       absorb;
		logic       finish;
		logic [7:0] data_byte;
	} work_t;

	typedef struct packed {
		logic       reload;
		logic [1:0] variant;
	} cfg_t;

	function automatic logic [HASH_W-1:0] start_value(input logic [1:0] variant);
		return (variant == VAR_FNV0) ? '0 : OFFSET_BASIS;
	endfunction

	// h * (2^344 + 0x157) mod 2^512
	function automatic logic [HASH_W-1:0] mul_prime(input logic [HASH_W-1:0] h);
		logic [HASH_W-1:0] acc;
		acc = h << PRIME_SHIFT;
		// low part of the prime is sparse: one shifted add per set bit
		for (int i = 0; i < $bits(PRIME_LOW); i++)
			if (PRIME_LOW[i])
				acc = acc + (h << i);
		return acc;
	endfunction

	function automatic logic [HASH_W-1:0] absorb_byte(input logic [HASH_W-1:0] h,
			input logic [7:0] b, input logic [1:0] variant);
		logic [HASH_W-1:0] bx;
		bx = {{(HASH_W-8){1'b0}}, b};
		if (variant == VAR_FNV0 || variant == VAR_FNV1)
			return mul_prime(h) ^ bx;
		else
			return mul_prime(h ^ bx);
	endfunction

endpackage

// ===== design/fnv512_front.sv =====
// Front end: decodes incoming items and queues them for the hash engine.
module fnv512_front
	import fnv512_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_item_t cmd,
	output logic      q_valid,
	output work_t     q_head,
	input  logic      q_pop
);

	work_t      fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	work_t      dec;
	logic       push;
	logic       take;

	always_comb begin
		dec.absorb = (cmd.operation == OP_ABSORB) || (cmd.operation == OP_ABSORB_FINISH);
		dec.finish = (cmd.operation == OP_ABSORB_FINISH) || (cmd.operation == OP_FINISH);
		dec.data_byte = cmd.data_byte;
	end

	assign cmd_stall = (count_q == 2'd2);
	assign take = cmd_valid && !cmd_stall;
	// code three is dropped here: no state change, no result
	assign push = take && (dec.absorb || dec.finish);
	assign q_valid = (count_q != 2'd0);
	assign q_head = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !q_pop)
				count_q <= count_q + 2'd1;
			else if (!push && q_pop)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

// ===== design/fnv512_back.sv =====
// Back end: hash state, FNV step and digest word output register.
module fnv512_back
	import fnv512_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       q_valid,
	input  work_t      q_head,
	output logic       q_pop,
	output logic       res_valid,
	input  logic       res_stall,
	output res_item_t  res
);

	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] dig_q;
	logic [IDX_W-1:0]  idx_q;
	logic              busy_q;
	logic [HASH_W-1:0] h_new;
	logic              res_take;
	logic              last_take;

	assign res_take = busy_q && !res_stall;
	assign last_take = res_take && (idx_q == IDX_W'(WORDS - 1));
	// a finish needs the digest buffer free (or freeing this cycle)
	assign q_pop = q_valid && (!q_head.finish || !busy_q || last_take);
	assign h_new = q_head.absorb ? absorb_byte(hash_q, q_head.data_byte, cfg.variant) : hash_q;

	assign res_valid = busy_q;
	assign res.digest_word = dig_q[HASH_W-1 -: WORD_W];
	assign res.word_index = idx_q;
	assign res.last_word = (idx_q == IDX_W'(WORDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= OFFSET_BASIS;
		end else if (cfg.reload) begin
			hash_q <= start_value(cfg.variant);
		end else if (q_pop) begin
			hash_q <= q_head.finish ? start_value(cfg.variant) : h_new;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.finish)
			dig_q <= h_new;
		else if (res_take)
			dig_q <= dig_q << WORD_W;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (q_pop && q_head.finish) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (res_take) begin
			idx_q <= idx_q + IDX_W'(1);
			if (last_take)
				busy_q <= 1'b0;
		end
	end

endmodule

// ===== design/fnv_hash_512_core.sv =====
// Top level of the 512-bit FNV hash core: register port, front and back.
//
//  channel | direction | handshake           | payload
//  cmd     | in        | cmd_valid/cmd_stall | operation, data_byte
//  res     | out       | res_valid/res_stall | digest_word, word_index, last_word
//  apb     | in        | psel/penable/pready | hash_variant at address 0
//
// One byte is absorbed per cycle unless a finish waits for the digest buffer;
// the 512-bit multiply-by-prime add is the loop. A finish yields eight words;
// bytes keep flowing meanwhile, a second finish waits for the buffer to drain.
// Reset loads the FNV-1a offset basis; a variant write reloads the start value.
// A two-entry queue decouples input stall from output stall.
module fnv_hash_512_core
	import fnv512_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  cmd_item_t          cmd,
	output logic               res_valid,
	input  logic               res_stall,
	output res_item_t          res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [1:0] variant_q;
	logic       wr_hit;
	cfg_t       cfg;
	logic       q_valid;
	work_t      q_head;
	logic       q_pop;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite && pready && (paddr[2] == REG_HASH_VARIANT[2]);
	assign prdata = (paddr[2] == REG_HASH_VARIANT[2]) ? {{(PDATA_W-2){1'b0}}, variant_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			variant_q <= VAR_FNV1A;
		else if (wr_hit)
			variant_q <= pwdata[1:0];
	end

	// reload uses the new variant in the cycle of the write
	assign cfg.reload = wr_hit;
	assign cfg.variant = wr_hit ? pwdata[1:0] : variant_q;

	fnv512_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop)
	);

	fnv512_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the 512-bit FNV hash core, all four variants.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fnv512_pkg::*;

	localparam int PERIOD = 10;
	localparam int QUIET_LIMIT = 5000;
	localparam int SETTLE = 24;
	localparam int HOLD = 300;

	// FNV-512 offset basis, least significant word on the right
	localparam logic [511:0] FNV512_BASIS = {
		64'hB86DB0B1171F4416, 64'hDCA1E50F309990AC,
		64'hAC87D059C9000000, 64'h0000000000000D21,
		64'hE948F68A34C192F6, 64'h2EA79BC942DBE7CE,
		64'h182036415F56E34B, 64'hAC982AAC4AFE9FD9
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_stall;
	cmd_item_t          cmd;
	logic               res_valid;
	logic               res_stall;
	res_item_t          res;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// predicted core state
	logic [511:0] hash_state;
	variant_e     hash_mode;
	res_item_t    expected_words[$];

	int  mismatch_count = 0;
	int  items_sent = 0;
	int  words_checked = 0;
	int  digests_predicted = 0;
	int  input_stall_cycles = 0;
	int  quiet_cycles = 0;
	int  hold_cycles = 0;
	bit  tx_idle_en = 1'b1;
	bit  rx_idle_en = 1'b1;

	always #(PERIOD / 2) clk = ~clk;

	fnv_hash_512_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// h * (2^344 + 0x157) mod 2^512; 0x157 = 256 + 64 + 16 + 4 + 2 + 1
	function automatic logic [511:0] times_fnv_prime(input logic [511:0] h);
		return (h << 344) + (h << 8) + (h << 6) + (h << 4) + (h << 2) + (h << 1) + h;
	endfunction

	function automatic logic [511:0] variant_start(input variant_e v);
		return (v == VAR_FNV0) ? '0 : FNV512_BASIS;
	endfunction

	// one command transfer; updates the predicted hash on acceptance
	task automatic send_item(input op_e op, input logic [7:0] b);
		int gap;
		int r;
		int k;
		res_item_t w;
		cmd_valid = 1'b1;
		cmd.operation = op;
		cmd.data_byte = b;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		items_sent++;
		if (op == OP_ABSORB || op == OP_ABSORB_FINISH) begin
			if (hash_mode == VAR_FNV0 || hash_mode == VAR_FNV1)
				hash_state = times_fnv_prime(hash_state) ^ 512'(b);
			else
				hash_state = times_fnv_prime(hash_state ^ 512'(b));
		end
		if (op == OP_ABSORB_FINISH || op == OP_FINISH) begin
			for (k = 0; k < 8; k++) begin
				w.digest_word = hash_state[64 * (7 - k) +: 64];
				w.word_index = IDX_W'(k);
				w.last_word = (k == 7);
				expected_words.push_back(w);
			end
			digests_predicted++;
			hash_state = variant_start(hash_mode);
		end
		@(negedge clk);
		gap = 0;
		if (tx_idle_en) begin
			r = $urandom_range(0, 99);
			if (r >= 92)
				gap = $urandom_range(8, 30);
			else if (r >= 60)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			cmd_valid = 1'b0;
			cmd = cmd_item_t'($urandom);
			repeat (gap) @(negedge clk);
		end
	endtask

	// drop valid, wait for all digest words, then let in-flight bytes land
	task automatic settle();
		cmd_valid = 1'b0;
		while (expected_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic reg_read(input variant_e want);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = REG_HASH_VARIANT;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== PDATA_W'(want)) begin
			$error("prdata: expected %0h, got %0h", PDATA_W'(want), prdata);
			mismatch_count++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_variant(input variant_e v);
		settle();
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = REG_HASH_VARIANT;
		pwdata = $urandom;
		pwdata[1:0] = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		hash_mode = v;
		hash_state = variant_start(v);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		reg_read(v);
	endtask

	// digest word checker
	always @(posedge clk) begin
		res_item_t want;
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (expected_words.size() == 0) begin
				$error("unexpected digest word: word %h index %0d last %b",
					res.digest_word, res.word_index, res.last_word);
				mismatch_count++;
			end else begin
				want = expected_words.pop_front();
				words_checked++;
				if (res.digest_word !== want.digest_word) begin
					$error("digest_word: expected %h, got %h",
						want.digest_word, res.digest_word);
					mismatch_count++;
				end
				if (res.word_index !== want.word_index) begin
					$error("word_index: expected %0d, got %0d",
						want.word_index, res.word_index);
					mismatch_count++;
				end
				if (res.last_word !== want.last_word) begin
					$error("last_word: expected %b, got %b",
						want.last_word, res.last_word);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer anywhere
	always @(posedge clk) begin
		if (cmd_valid === 1'b1 && cmd_stall === 1'b1)
			input_stall_cycles++;
		if ((cmd_valid === 1'b1 && cmd_stall === 1'b0) ||
				(res_valid === 1'b1 && res_stall === 1'b0) ||
				(psel === 1'b1 && penable === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random stall bursts, plus a long hold-off on request
	initial begin
		int run;
		int r;
		res_stall = 1'b0;
		run = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				res_stall = 1'b1;
				hold_cycles--;
			end else if (run > 0) begin
				res_stall = 1'b1;
				run--;
			end else begin
				res_stall = 1'b0;
				if (rx_idle_en) begin
					r = $urandom_range(0, 99);
					if (r < 12)
						run = $urandom_range(1, 3);
					else if (r < 15)
						run = $urandom_range(8, 40);
				end
			end
		end
	end

	task automatic test_reset_state();
		reg_read(VAR_FNV1A);
		// empty message: digest is the basis; the byte is ignored
		send_item(OP_FINISH, 8'hFF);
	endtask

	task automatic test_byte_extremes();
		send_item(OP_ABSORB, 8'h00);
		send_item(OP_ABSORB, 8'hFF);
		send_item(OP_NONE, 8'h5A);
		send_item(OP_ABSORB_FINISH, 8'h80);
		send_item(OP_FINISH, 8'h00);
	endtask

	task automatic test_variants_directed();
		variant_e v;
		for (int i = 0; i < 4; i++) begin
			v = variant_e'(i);
			set_variant(v);
			send_item(OP_ABSORB, 8'h01);
			send_item(OP_ABSORB_FINISH, 8'hFE);
			send_item(OP_FINISH, 8'h7F);
		end
	endtask

	// a register write throws away a partly absorbed message
	task automatic test_reload_on_write();
		send_item(OP_ABSORB, 8'h12);
		send_item(OP_ABSORB, 8'hED);
		send_item(OP_ABSORB, 8'h3C);
		set_variant(VAR_FNV1);
		send_item(OP_FINISH, 8'hC3);
	endtask

	task automatic test_random_messages(input variant_e v, input int budget,
			input bit tx_en, input bit rx_en);
		int sent;
		int len;
		set_variant(v);
		tx_idle_en = tx_en;
		rx_idle_en = rx_en;
		sent = 0;
		while (sent < budget) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 19) == 0)
					send_item(OP_NONE, 8'($urandom));
				send_item(OP_ABSORB, 8'($urandom));
				sent++;
			end
			// sometimes no finish: the message runs on into the next one
			if ($urandom_range(0, 9) != 0) begin
				send_item($urandom_range(0, 1) ? OP_ABSORB_FINISH : OP_FINISH, 8'($urandom));
				sent++;
			end
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// receiver holds off while the sender keeps going
	task automatic test_backpressure();
		tx_idle_en = 1'b0;
		hold_cycles = HOLD;
		for (int i = 0; i < 48; i++)
			send_item((i % 6 == 5) ? OP_ABSORB_FINISH : OP_ABSORB, 8'($urandom));
		tx_idle_en = 1'b1;
	endtask

	// sender stops until the whole digest is out, then resumes
	task automatic test_sender_pause();
		repeat (3) begin
			repeat (4) send_item(OP_ABSORB, 8'($urandom));
			send_item(OP_ABSORB_FINISH, 8'($urandom));
			settle();
			repeat ($urandom_range(5, 30)) @(negedge clk);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hash_mode = VAR_FNV1A;
		hash_state = FNV512_BASIS;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_state();
		test_byte_extremes();
		test_variants_directed();
		test_reload_on_write();
		test_random_messages(VAR_FNV0, 55, 1'b1, 1'b1);
		test_random_messages(VAR_ALT1A, 55, 1'b0, 1'b1);
		test_random_messages(VAR_FNV1, 55, 1'b1, 1'b0);
		test_random_messages(VAR_FNV1A, 55, 1'b0, 1'b0);
		test_backpressure();
		test_sender_pause();
		settle();

		$display("Covered %0d command transfers over FNV-0, FNV-1, FNV-1a and code three,",
			items_sent);
		$display("%0d digests / %0d words checked, %0d cycles of input stall seen.",
			digests_predicted, words_checked, input_stall_cycles);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== fnv_hash_512_core.f =====
design/fnv512_pkg.sv
design/fnv512_front.sv
design/fnv512_back.sv
design/fnv_hash_512_core.sv
tb/tb_top.sv
